FILE: rtl/core/pts_pkg.sv
// shared types, constants and opcodes of the priority thread scheduler
`default_nettype none
package pts_pkg;
    localparam int THREAD_SLOTS   = 8;
    localparam int PERIODIC_SLOTS = 8;
    localparam int SLOT_W  = $clog2(THREAD_SLOTS);
    localparam int EVT_W   = $clog2(PERIODIC_SLOTS);
    localparam int LIVE_W  = $clog2(THREAD_SLOTS + 1);
    localparam int ECNT_W  = $clog2(PERIODIC_SLOTS + 1);
    localparam int QDEPTH  = 2;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_ADD      = 3'd2,
        OP_KILL     = 3'd3,
        OP_SLEEP    = 3'd4,
        OP_BLOCK    = 3'd5,
        OP_PERIODIC = 3'd6,
        OP_NOP      = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_NO_THREADS = 3'd2,
        ST_NO_SUCH    = 3'd3,
        ST_EVT_LIMIT  = 3'd4,
        ST_NONE_READY = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  priority_req;
        logic [31:0] thread_id;
        logic [2:0]  block_slot;
        logic        block_flag;
        logic [31:0] sleep_duration;
        logic [31:0] event_period;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  chosen_slot;
        logic [31:0] new_thread_id;
        logic        switch_request;
        logic [7:0]  fired_events;
        logic [31:0] time_now;
    } rsp_t;

    // decoded request handed from front to back
    typedef struct packed {
        opcode_t     op;
        logic [7:0]  prio;
        logic [31:0] thread_id;
        logic [2:0]  block_slot;
        logic        block_flag;
        logic [31:0] operand;
    } cmd_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_EVENTS,
        EX_WAKE,
        EX_WALK,
        EX_SEARCH,
        EX_LINK,
        EX_DONE
    } ex_state_t;
endpackage
`default_nettype wire

FILE: rtl/core/pts_front.sv
// front end: accepts requests, decodes them and queues commands
`default_nettype none
module pts_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pts_pkg::req_t s_data,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output pts_pkg::cmd_t      cmd_data
);
    localparam int PTR_W = $clog2(pts_pkg::QDEPTH);

    pts_pkg::cmd_t q_mem [pts_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    pts_pkg::cmd_t    dec;
    logic             push, pop;

    // pick the one operand the opcode needs
    always_comb begin
        dec.op         = pts_pkg::opcode_t'(s_data.opcode);
        dec.prio       = s_data.priority_req;
        dec.thread_id  = s_data.thread_id;
        dec.block_slot = s_data.block_slot;
        dec.block_flag = s_data.block_flag;
        case (dec.op)
            pts_pkg::OP_SLEEP: dec.operand = s_data.sleep_duration;
            default:           dec.operand = s_data.event_period;
        endcase
    end

    assign s_ready   = (cnt_reg != (PTR_W+1)'(pts_pkg::QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_data  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/pts_back.sv
// back end: thread table, ring, event table and the slot-serial walks
`default_nettype none
module pts_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire pts_pkg::cmd_t cmd_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pts_pkg::rsp_t      m_data
);
    localparam int SW = pts_pkg::SLOT_W;
    localparam int EW = pts_pkg::EVT_W;
    localparam int NS = pts_pkg::THREAD_SLOTS;
    localparam int NE = pts_pkg::PERIODIC_SLOTS;
    localparam int LW = pts_pkg::LIVE_W;
    localparam int CW = pts_pkg::ECNT_W;

    logic [NS-1:0] alive_reg, asleep_reg, blocked_reg;
    logic [7:0]    prio_mem  [NS];
    logic [31:0]   wake_mem  [NS];
    logic [SW-1:0] next_mem  [NS];
    logic [SW-1:0] prev_mem  [NS];
    logic [31:0]   id_mem    [NS];
    logic [31:0]   per_mem   [NE];
    logic [31:0]   last_mem  [NE];

    logic [SW-1:0] cur_reg;
    logic [LW-1:0] live_reg;
    logic [15:0]   idc_reg;
    logic [31:0]   tick_reg;
    logic [CW-1:0] ecnt_reg;

    pts_pkg::ex_state_t state_reg, state_next;
    pts_pkg::cmd_t cmd_reg;
    logic [SW:0]   idx_reg;     // step counter, one wider to hold the slot count
    logic [SW-1:0] node_reg, best_reg;
    logic [7:0]    bestp_reg;
    logic          found_reg;
    logic [7:0]    fired_reg;
    logic [SW-1:0] hit_reg;
    logic          hit_ok_reg;
    logic          outv_reg;
    logic          evt_full_reg;
    pts_pkg::rsp_t out_reg;

    logic [SW-1:0] sidx;
    logic [EW-1:0] eidx;
    logic [32:0]   due;
    logic          last_step, node_ready, better;
    logic          start, finish;

    assign sidx      = idx_reg[SW-1:0];
    assign eidx      = idx_reg[EW-1:0];
    assign due       = {1'b0, last_mem[eidx]} + {1'b0, per_mem[eidx]};
    assign node_ready = alive_reg[node_reg] && !asleep_reg[node_reg] && !blocked_reg[node_reg];
    assign better    = !found_reg || (prio_mem[node_reg] < bestp_reg);
    assign last_step = (idx_reg == (SW+1)'(NS - 1));
    assign start     = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == pts_pkg::EX_IDLE);
    assign finish    = (state_reg == pts_pkg::EX_DONE) && (!outv_reg || m_ready);
    assign m_valid   = outv_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::EX_IDLE: begin
                if (cmd_valid) begin
                    case (cmd_data.op)
                        pts_pkg::OP_TICK:
                            state_next = (ecnt_reg != '0) ? pts_pkg::EX_EVENTS
                                                          : pts_pkg::EX_WAKE;
                        pts_pkg::OP_SCHEDULE:
                            state_next = (live_reg != '0) ? pts_pkg::EX_WALK
                                                          : pts_pkg::EX_DONE;
                        pts_pkg::OP_ADD, pts_pkg::OP_KILL:
                            state_next = pts_pkg::EX_SEARCH;
                        default: state_next = pts_pkg::EX_DONE;
                    endcase
                end
            end
            pts_pkg::EX_EVENTS: begin
                if ((idx_reg + 1'b1) >= (SW+1)'(ecnt_reg) || idx_reg == (SW+1)'(NE - 1))
                    state_next = pts_pkg::EX_WAKE;
            end
            pts_pkg::EX_WAKE:   if (last_step) state_next = pts_pkg::EX_DONE;
            pts_pkg::EX_WALK:   if (last_step) state_next = pts_pkg::EX_DONE;
            pts_pkg::EX_SEARCH: if (last_step) state_next = pts_pkg::EX_LINK;
            pts_pkg::EX_LINK:   state_next = pts_pkg::EX_DONE;
            pts_pkg::EX_DONE:   if (finish) state_next = pts_pkg::EX_IDLE;
            default:            state_next = pts_pkg::EX_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pts_pkg::EX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // step counter and walk registers
    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg    <= cmd_data;
            idx_reg    <= '0;
            node_reg   <= next_mem[cur_reg];
            found_reg  <= 1'b0;
            fired_reg  <= '0;
            hit_ok_reg <= 1'b0;
            hit_reg    <= '0;
        end else begin
            unique case (state_reg)
                pts_pkg::EX_EVENTS: begin
                    if (state_next == pts_pkg::EX_WAKE) idx_reg <= '0;
                    else idx_reg <= idx_reg + 1'b1;
                    if ({1'b0, tick_reg} >= due && idx_reg < (SW+1)'(8))
                        fired_reg[idx_reg[2:0]] <= 1'b1;
                end
                pts_pkg::EX_WAKE: idx_reg <= idx_reg + 1'b1;
                pts_pkg::EX_WALK: begin
                    if (node_ready && better) begin
                        found_reg <= 1'b1;
                        best_reg  <= node_reg;
                        bestp_reg <= prio_mem[node_reg];
                    end
                    node_reg <= next_mem[node_reg];
                    idx_reg  <= idx_reg + 1'b1;
                end
                pts_pkg::EX_SEARCH: begin
                    // lowest free slot for add, lowest live id match for kill
                    if (!hit_ok_reg) begin
                        if (cmd_reg.op == pts_pkg::OP_ADD ? !alive_reg[sidx]
                            : (alive_reg[sidx] && id_mem[sidx] == cmd_reg.thread_id)) begin
                            hit_ok_reg <= 1'b1;
                            hit_reg    <= sidx;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg   <= '0;
            asleep_reg  <= '0;
            blocked_reg <= '0;
            cur_reg     <= '0;
            live_reg    <= '0;
            idc_reg     <= '0;
            tick_reg    <= '0;
            ecnt_reg    <= '0;
        end else begin
            if (start && cmd_data.op == pts_pkg::OP_TICK) tick_reg <= tick_reg + 1'b1;
            if (state_reg == pts_pkg::EX_WAKE && alive_reg[sidx] && asleep_reg[sidx]
                && wake_mem[sidx] == tick_reg)
                asleep_reg[sidx] <= 1'b0;
            if (start) begin
                case (cmd_data.op)
                    pts_pkg::OP_SLEEP: if (live_reg != '0) asleep_reg[cur_reg] <= 1'b1;
                    pts_pkg::OP_BLOCK:
                        blocked_reg[cmd_data.block_slot[SW-1:0]] <= cmd_data.block_flag;
                    pts_pkg::OP_PERIODIC:
                        if (ecnt_reg != CW'(NE)) ecnt_reg <= ecnt_reg + 1'b1;
                    default: ;
                endcase
            end
            if (state_reg == pts_pkg::EX_WALK && last_step) begin
                if (found_reg || (node_ready && better))
                    cur_reg <= (node_ready && better) ? node_reg : best_reg;
            end
            if (state_reg == pts_pkg::EX_LINK && hit_ok_reg) begin
                if (cmd_reg.op == pts_pkg::OP_ADD) begin
                    alive_reg[hit_reg]   <= 1'b1;
                    asleep_reg[hit_reg]  <= 1'b0;
                    blocked_reg[hit_reg] <= 1'b0;
                    live_reg <= live_reg + 1'b1;
                    idc_reg  <= idc_reg + 1'b1;
                end else if (live_reg != '0) begin
                    alive_reg[hit_reg] <= 1'b0;
                    live_reg <= live_reg - 1'b1;
                end
            end
        end
    end

    // payload stores
    always_ff @(posedge aclk) begin
        if (start && cmd_data.op == pts_pkg::OP_SLEEP && live_reg != '0)
            wake_mem[cur_reg] <= tick_reg + cmd_data.operand;
        if (start && cmd_data.op == pts_pkg::OP_PERIODIC && ecnt_reg != CW'(NE)) begin
            per_mem[ecnt_reg[EW-1:0]]  <= cmd_data.operand;
            last_mem[ecnt_reg[EW-1:0]] <= tick_reg + 32'(ecnt_reg);
        end
        if (state_reg == pts_pkg::EX_EVENTS && {1'b0, tick_reg} >= due)
            last_mem[eidx] <= tick_reg;
        if (state_reg == pts_pkg::EX_LINK && hit_ok_reg) begin
            if (cmd_reg.op == pts_pkg::OP_ADD) begin
                prio_mem[hit_reg] <= cmd_reg.prio;
                id_mem[hit_reg]   <= {idc_reg, 16'(hit_reg)};
                if (live_reg == '0) begin
                    next_mem[hit_reg] <= hit_reg;
                    prev_mem[hit_reg] <= hit_reg;
                end else begin
                    prev_mem[hit_reg]           <= cur_reg;
                    next_mem[hit_reg]           <= next_mem[cur_reg];
                    next_mem[cur_reg]           <= hit_reg;
                    prev_mem[next_mem[cur_reg]] <= hit_reg;
                end
            end else if (live_reg != '0) begin
                prev_mem[next_mem[hit_reg]] <= prev_mem[hit_reg];
                next_mem[prev_mem[hit_reg]] <= next_mem[hit_reg];
            end
        end
    end

    // result register, built from state as it stands in the done step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outv_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) outv_reg <= 1'b0;
            if (finish) outv_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_reg.status         <= pts_pkg::ST_OK;
            out_reg.chosen_slot    <= '0;
            out_reg.new_thread_id  <= '0;
            out_reg.switch_request <= 1'b0;
            out_reg.fired_events   <= '0;
            out_reg.time_now       <= tick_reg;
            case (cmd_reg.op)
                pts_pkg::OP_TICK: begin
                    out_reg.switch_request <= 1'b1;
                    out_reg.fired_events   <= fired_reg;
                end
                pts_pkg::OP_SCHEDULE: begin
                    if (live_reg == '0) out_reg.status <= pts_pkg::ST_NO_THREADS;
                    else if (!found_reg) out_reg.status <= pts_pkg::ST_NONE_READY;
                    else begin
                        out_reg.chosen_slot    <= 3'(cur_reg);
                        out_reg.switch_request <= 1'b1;
                    end
                end
                pts_pkg::OP_ADD: begin
                    if (!hit_ok_reg) out_reg.status <= pts_pkg::ST_NO_FREE;
                    else begin
                        out_reg.chosen_slot   <= 3'(hit_reg);
                        out_reg.new_thread_id <= id_mem[hit_reg];
                    end
                end
                pts_pkg::OP_KILL: begin
                    // live count already dropped on a hit, so test the hit first
                    if (hit_ok_reg) out_reg.switch_request <= (hit_reg == cur_reg);
                    else if (live_reg == '0) out_reg.status <= pts_pkg::ST_NO_THREADS;
                    else out_reg.status <= pts_pkg::ST_NO_SUCH;
                end
                pts_pkg::OP_SLEEP: begin
                    if (live_reg == '0) out_reg.status <= pts_pkg::ST_NO_THREADS;
                    else out_reg.switch_request <= 1'b1;
                end
                pts_pkg::OP_PERIODIC: begin
                    if (evt_full_reg) out_reg.status <= pts_pkg::ST_EVT_LIMIT;
                end
                default: ;
            endcase
        end
    end

    // event table was already full when the add was taken
    always_ff @(posedge aclk) begin
        if (start) evt_full_reg <= (ecnt_reg == CW'(NE));
    end
endmodule
`default_nettype wire

FILE: rtl/core/priority_thread_scheduler_unit.sv
// top level of the priority thread scheduler
// simple operations go straight to done; schedule walks the ring; add and kill
// search the slots then link; a tick checks the events in use, then the slots
// throughput: one request at a time in the back end, set by the slot-serial walk
// the front queue holds two more requests
// reset: synchronous active-low aresetn clears the slot marks, counters and queue
`default_nettype none
module priority_thread_scheduler_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pts_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pts_pkg::rsp_t      m_data
);
    logic          cmd_valid, cmd_ready;
    pts_pkg::cmd_t cmd_data;

    pts_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .cmd_valid, .cmd_ready, .cmd_data
    );

    pts_back u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

FILE: rtl/core/pts_checker.sv
// port-level checker for the priority thread scheduler, bound to the top level
`default_nettype none
module pts_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire pts_pkg::req_t s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire pts_pkg::rsp_t m_data
);
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data)) else $error("request dropped");
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_time_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.fired_events != '0 |-> m_data.switch_request)
        else $error("events fired outside a tick");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= 3'd5) else $error("bad status");
    a_add_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.new_thread_id != '0 |->
        m_data.new_thread_id[2:0] == m_data.chosen_slot) else $error("id slot mismatch");
endmodule

bind priority_thread_scheduler_unit pts_checker u_pts_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the priority thread scheduler: random and directed requests
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pts_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pts_pkg::rsp_t m_data;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    priority_thread_scheduler_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    class sched_scoreboard;
        bit          alive [pts_pkg::THREAD_SLOTS];
        logic [7:0]  prio [pts_pkg::THREAD_SLOTS];
        bit          asleep [pts_pkg::THREAD_SLOTS];
        bit          blocked [pts_pkg::THREAD_SLOTS];
        logic [31:0] wake_at [pts_pkg::THREAD_SLOTS];
        logic [2:0]  nxt [pts_pkg::THREAD_SLOTS];
        logic [2:0]  prv [pts_pkg::THREAD_SLOTS];
        logic [31:0] tid [pts_pkg::THREAD_SLOTS];
        logic [2:0]  cur;
        int          live;
        logic [15:0] id_ctr;
        logic [31:0] ticks;
        int          evt_cnt;
        logic [31:0] evt_period [pts_pkg::PERIODIC_SLOTS];
        logic [31:0] evt_last [pts_pkg::PERIODIC_SLOTS];
        pts_pkg::rsp_t pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < pts_pkg::THREAD_SLOTS; i++) begin
                alive[i] = 0; asleep[i] = 0; blocked[i] = 0;
                prio[i] = 0; wake_at[i] = 0; nxt[i] = 0; prv[i] = 0; tid[i] = 0;
            end
            for (int i = 0; i < pts_pkg::PERIODIC_SLOTS; i++) begin
                evt_period[i] = 0; evt_last[i] = 0;
            end
            cur = 0; live = 0; id_ctr = 0; ticks = 0; evt_cnt = 0;
            errors = 0;
        endfunction

        function logic [31:0] live_id(int k);
            return tid[k];
        endfunction

        function void note_request(pts_pkg::req_t r);
            pts_pkg::rsp_t o;
            logic [32:0] due;
            int s, best;
            logic [7:0] best_p;
            logic [2:0] node, nx, pv;
            bit found;
            o = '0;
            case (pts_pkg::opcode_t'(r.opcode))
                pts_pkg::OP_TICK: begin
                    ticks = ticks + 1;
                    for (int i = 0; i < evt_cnt; i++) begin
                        due = {1'b0, evt_last[i]} + {1'b0, evt_period[i]};
                        if ({1'b0, ticks} >= due) begin
                            o.fired_events[i] = 1'b1;
                            evt_last[i] = ticks;
                        end
                    end
                    for (int i = 0; i < pts_pkg::THREAD_SLOTS; i++)
                        if (alive[i] && asleep[i] && wake_at[i] == ticks) asleep[i] = 0;
                    o.switch_request = 1;
                end
                pts_pkg::OP_SCHEDULE: begin
                    if (live == 0) begin
                        o.status = pts_pkg::ST_NO_THREADS;
                    end else begin
                        node = nxt[cur];
                        found = 0; best = 0; best_p = 0;
                        for (int i = 0; i < pts_pkg::THREAD_SLOTS; i++) begin
                            if (alive[node] && !asleep[node] && !blocked[node]) begin
                                if (!found || prio[node] < best_p) begin
                                    found = 1; best = node; best_p = prio[node];
                                end
                            end
                            node = nxt[node];
                        end
                        if (found) begin
                            cur = 3'(best); o.chosen_slot = 3'(best); o.switch_request = 1;
                        end else begin
                            o.status = pts_pkg::ST_NONE_READY;
                        end
                    end
                end
                pts_pkg::OP_ADD: begin
                    s = pts_pkg::THREAD_SLOTS;
                    for (int i = pts_pkg::THREAD_SLOTS - 1; i >= 0; i--)
                        if (!alive[i]) s = i;
                    if (s == pts_pkg::THREAD_SLOTS) begin
                        o.status = pts_pkg::ST_NO_FREE;
                    end else begin
                        asleep[s] = 0; blocked[s] = 0; prio[s] = r.priority_req;
                        tid[s] = {id_ctr, 16'(s)};
                        id_ctr = id_ctr + 16'd1;
                        if (live == 0) begin
                            nxt[s] = 3'(s); prv[s] = 3'(s);
                        end else begin
                            nx = nxt[cur];
                            prv[s] = cur; nxt[s] = nx; nxt[cur] = 3'(s); prv[nx] = 3'(s);
                        end
                        alive[s] = 1; live++;
                        o.chosen_slot = 3'(s); o.new_thread_id = tid[s];
                    end
                end
                pts_pkg::OP_KILL: begin
                    if (live == 0) begin
                        o.status = pts_pkg::ST_NO_THREADS;
                    end else begin
                        s = pts_pkg::THREAD_SLOTS;
                        for (int i = pts_pkg::THREAD_SLOTS - 1; i >= 0; i--)
                            if (alive[i] && tid[i] == r.thread_id) s = i;
                        if (s == pts_pkg::THREAD_SLOTS) begin
                            o.status = pts_pkg::ST_NO_SUCH;
                        end else begin
                            nx = nxt[s]; pv = prv[s];
                            alive[s] = 0; prv[nx] = pv; nxt[pv] = nx; live--;
                            if (s == int'(cur)) o.switch_request = 1;
                        end
                    end
                end
                pts_pkg::OP_SLEEP: begin
                    if (live == 0) begin
                        o.status = pts_pkg::ST_NO_THREADS;
                    end else begin
                        wake_at[cur] = ticks + r.sleep_duration;
                        asleep[cur] = 1; o.switch_request = 1;
                    end
                end
                pts_pkg::OP_BLOCK: blocked[r.block_slot] = r.block_flag;
                pts_pkg::OP_PERIODIC: begin
                    if (evt_cnt < pts_pkg::PERIODIC_SLOTS) begin
                        evt_period[evt_cnt] = r.event_period;
                        evt_last[evt_cnt] = ticks + 32'(evt_cnt);
                        evt_cnt++;
                    end else begin
                        o.status = pts_pkg::ST_EVT_LIMIT;
                    end
                end
                default: ;
            endcase
            o.time_now = ticks;
            pending.push_back(o);
        endfunction

        function void check_result(pts_pkg::rsp_t got);
            pts_pkg::rsp_t w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status || got.chosen_slot !== w.chosen_slot ||
                got.new_thread_id !== w.new_thread_id ||
                got.switch_request !== w.switch_request ||
                got.fired_events !== w.fired_events || got.time_now !== w.time_now) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected st=%0d slot=%0d id=%h sw=%b ev=%h t=%0d,",
                              " got st=%0d slot=%0d id=%h sw=%b ev=%h t=%0d"},
                        w.status, w.chosen_slot, w.new_thread_id, w.switch_request,
                        w.fired_events, w.time_now, got.status, got.chosen_slot,
                        got.new_thread_id, got.switch_request, got.fired_events,
                        got.time_now);
            end
        endfunction
    endclass

    sched_scoreboard sb;
    bit calm_phase = 0;
    int idle_cycles = 0;

    // result side: random stall, checks each accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= calm_phase || ($urandom_range(99) >= 32);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays up between back-to-back requests and drops only while idling
    task automatic send_request(pts_pkg::req_t r);
        while (!calm_phase && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    function automatic pts_pkg::req_t rand_fields(pts_pkg::opcode_t op);
        pts_pkg::req_t r;
        r.opcode = op;
        r.priority_req = 8'($urandom);
        r.thread_id = $urandom;
        r.block_slot = 3'($urandom);
        r.block_flag = 1'($urandom);
        r.sleep_duration = $urandom;
        r.event_period = $urandom;
        return r;
    endfunction

    // mostly valid ids, short sleeps and short periods so threads come back
    function automatic pts_pkg::req_t pick_request();
        pts_pkg::req_t r;
        int k, pick;
        pick = $urandom_range(99);
        if (pick < 22) r = rand_fields(pts_pkg::OP_TICK);
        else if (pick < 40) r = rand_fields(pts_pkg::OP_SCHEDULE);
        else if (pick < 55) r = rand_fields(pts_pkg::OP_ADD);
        else if (pick < 67) r = rand_fields(pts_pkg::OP_KILL);
        else if (pick < 76) r = rand_fields(pts_pkg::OP_SLEEP);
        else if (pick < 88) r = rand_fields(pts_pkg::OP_BLOCK);
        else if (pick < 93) r = rand_fields(pts_pkg::OP_PERIODIC);
        else r = rand_fields(pts_pkg::OP_NOP);
        if (r.opcode == pts_pkg::OP_KILL && $urandom_range(3) != 0) begin
            k = $urandom_range(pts_pkg::THREAD_SLOTS - 1);
            r.thread_id = sb.alive[k] ? sb.live_id(k) : {sb.id_ctr - 16'd1, 16'(k)};
        end
        if (r.opcode == pts_pkg::OP_SLEEP && $urandom_range(4) != 0)
            r.sleep_duration = $urandom_range(6);
        if (r.opcode == pts_pkg::OP_PERIODIC && $urandom_range(3) != 0)
            r.event_period = $urandom_range(5);
        if ($urandom_range(3) == 0) r.priority_req = 8'($urandom_range(3));
        return r;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        pts_pkg::req_t r;
        sb = new();
        sb.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases, fill, extremes, full tables
        r = rand_fields(pts_pkg::OP_SCHEDULE); send_request(r);
        r = rand_fields(pts_pkg::OP_KILL); send_request(r);
        r = rand_fields(pts_pkg::OP_SLEEP); send_request(r);
        r = rand_fields(pts_pkg::OP_TICK); send_request(r);
        r = rand_fields(pts_pkg::OP_NOP); send_request(r);
        for (int i = 0; i < 9; i++) begin
            r = rand_fields(pts_pkg::OP_ADD);
            r.priority_req = (i == 0) ? 8'd255 : (i == 1) ? 8'd0 : 8'd0;
            send_request(r);
        end
        r = rand_fields(pts_pkg::OP_SCHEDULE); send_request(r);
        r = rand_fields(pts_pkg::OP_PERIODIC); r.event_period = 32'hFFFF_FFFF;
        send_request(r);
        r = rand_fields(pts_pkg::OP_PERIODIC); r.event_period = 0; send_request(r);
        r = rand_fields(pts_pkg::OP_SLEEP); r.sleep_duration = 32'hFFFF_FFFF;
        send_request(r);
        r = rand_fields(pts_pkg::OP_SLEEP); r.sleep_duration = 1; send_request(r);
        r = rand_fields(pts_pkg::OP_BLOCK); r.block_slot = 7; r.block_flag = 1;
        send_request(r);
        r = rand_fields(pts_pkg::OP_BLOCK); r.block_slot = 0; r.block_flag = 0;
        send_request(r);
        r = rand_fields(pts_pkg::OP_TICK); send_request(r);
        r = rand_fields(pts_pkg::OP_KILL); r.thread_id = sb.live_id(0); send_request(r);
        r = rand_fields(pts_pkg::OP_KILL); r.thread_id = 32'hFFFF_FFFF; send_request(r);
        r = rand_fields(pts_pkg::OP_SCHEDULE); send_request(r);
        r = rand_fields(pts_pkg::OP_ADD); send_request(r);
        for (int i = 0; i < 7; i++) begin
            r = rand_fields(pts_pkg::OP_PERIODIC); r.event_period = i; send_request(r);
        end

        // sender holds off until every result is back
        wait_drained();

        for (int n = 0; n < 900; n++) begin
            calm_phase = (n >= 300 && n < 420);
            send_request(pick_request());
        end
        calm_phase = 0;
        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
